>>> rtl/core/crcf_pkg.sv
// Package for the CRC-8 frame codec: word types, field layout and the CRC network.
`timescale 1ns / 1ps

package crcf_pkg;

  localparam int SOURCE_BITS  = 4;
  localparam int LENGTH_BITS  = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int FRAME_BITS = 64;
  localparam int START_BITS = 4;
  localparam int CRC_POS    = 56;
  localparam int CRC_BITS   = 8;

  localparam logic [START_BITS-1:0] START_CODE = 4'hD;
  localparam logic [CRC_BITS-1:0]   CRC_POLY   = 8'h07;

  localparam int SRC_POS = START_BITS;
  localparam int LEN_POS = SRC_POS + SOURCE_BITS;
  localparam int PAY_POS = LEN_POS + LENGTH_BITS;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_START = 2'd1,
    STATUS_BAD_CRC   = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t     req_type;
    logic [63:0]   frame_in;
    logic [3:0]    src_in;
    logic [15:0]   length_in;
    logic [31:0]   payload_in;
  } req_t;

  typedef struct packed {
    logic [63:0]   frame_out;
    status_t       status;
    logic [3:0]    src_out;
    logic [15:0]   length_out;
    logic [31:0]   payload_out;
  } rsp_t;

  function automatic logic [FRAME_BITS-1:0] low_mask(input int w);
    logic [FRAME_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (i < w) m[i] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [FRAME_BITS-1:0] BODY_MASK = low_mask(CRC_POS);
  localparam logic [FRAME_BITS-1:0] SRC_MASK  = low_mask(SOURCE_BITS);
  localparam logic [FRAME_BITS-1:0] LEN_MASK  = low_mask(LENGTH_BITS);
  localparam logic [FRAME_BITS-1:0] PAY_MASK  = low_mask(PAYLOAD_BITS);

  // Column k holds the frame bits that feed CRC bit k; the CRC is linear,
  // so run the serial update once per unit frame at elaboration.
  function automatic logic [CRC_BITS-1:0][FRAME_BITS-1:0] crc_masks();
    logic [CRC_BITS-1:0][FRAME_BITS-1:0] m;
    logic [CRC_BITS-1:0] c;
    m = '0;
    for (int j = 0; j < FRAME_BITS; j++) begin
      c = '0;
      for (int i = 0; i < FRAME_BITS / CRC_BITS; i++) begin
        if ((j >> 3) == i) c = c ^ (8'h01 << (j & 7));
        for (int b = 0; b < CRC_BITS; b++) begin
          c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
      end
      for (int k = 0; k < CRC_BITS; k++) begin
        m[k][j] = c[k];
      end
    end
    return m;
  endfunction

  localparam logic [CRC_BITS-1:0][FRAME_BITS-1:0] CRC_MASK = crc_masks();

endpackage

>>> rtl/core/crcf_crc8.sv
// CRC-8 (poly 0x07, init 0) over a 64-bit frame as a flat XOR network.
`timescale 1ns / 1ps

module crcf_crc8
  import crcf_pkg::*;
(
  input  logic [FRAME_BITS-1:0] frame,
  output logic [CRC_BITS-1:0]   crc
);

  always_comb begin
    for (int k = 0; k < CRC_BITS; k++) begin
      crc[k] = ^(frame & CRC_MASK[k]);
    end
  end

endmodule

>>> rtl/core/crc8_packet_framer_deframer.sv
// Top level of the CRC-8 frame codec: input stage, codec logic, result stage.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+-------------
//   request | req_valid | req_stall | req (req_t)
//   result  | rsp_valid | rsp_stall | rsp (rsp_t)
//
// One word per cycle sustained while the result side does not stall. A request
// loads the input register at the edge that takes it; its result loads the
// result register when the result stage advances. The CRC is one XOR tree per
// CRC bit between the two registers.
// rst is synchronous and clears both valid flags.
// A stall on the result side holds both stages; the request stage still takes
// a word while a finished result waits, and stalls only when both are full.
`timescale 1ns / 1ps

module crc8_packet_framer_deframer
  import crcf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic  s1_valid;
  req_t  s1;
  logic  advance;
  rsp_t  rsp_next;

  logic [FRAME_BITS-1:0] enc_body;
  logic [FRAME_BITS-1:0] dec_body;
  logic [FRAME_BITS-1:0] crc_body;
  logic [CRC_BITS-1:0]   crc;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;

  always_comb begin
    enc_body = {{(FRAME_BITS-START_BITS){1'b0}}, START_CODE}
             | (({60'b0, s1.src_in} & SRC_MASK) << SRC_POS)
             | (({48'b0, s1.length_in} & LEN_MASK) << LEN_POS)
             | (({32'b0, s1.payload_in} & PAY_MASK) << PAY_POS);
    enc_body = enc_body & BODY_MASK;
    dec_body = s1.frame_in & BODY_MASK;
    crc_body = (s1.req_type == REQ_ENCODE) ? enc_body : dec_body;
  end

  crcf_crc8 u_crc (
    .frame (crc_body),
    .crc   (crc)
  );

  always_comb begin
    logic [FRAME_BITS-1:0] src_f;
    logic [FRAME_BITS-1:0] len_f;
    logic [FRAME_BITS-1:0] pay_f;
    src_f    = (dec_body >> SRC_POS) & SRC_MASK;
    len_f    = (dec_body >> LEN_POS) & LEN_MASK;
    pay_f    = (dec_body >> PAY_POS) & PAY_MASK;
    rsp_next = '0;
    if (s1.req_type == REQ_ENCODE) begin
      rsp_next.frame_out = enc_body | ({56'b0, crc} << CRC_POS);
      rsp_next.status    = STATUS_OK;
    end else if (s1.frame_in[START_BITS-1:0] != START_CODE) begin
      rsp_next.status = STATUS_BAD_START;
    end else if (crc != s1.frame_in[CRC_POS +: CRC_BITS]) begin
      rsp_next.status = STATUS_BAD_CRC;
    end else begin
      rsp_next.status      = STATUS_OK;
      rsp_next.src_out     = src_f[3:0];
      rsp_next.length_out  = len_f[15:0];
      rsp_next.payload_out = pay_f[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (advance) begin
        rsp_valid <= s1_valid;
        s1_valid  <= req_valid;
      end else if (!s1_valid) begin
        s1_valid <= req_valid;
      end
    end
  end

  // Payload registers: load the input stage whenever it can take a word.
  always_ff @(posedge clk) begin
    if (advance || !s1_valid) begin
      s1 <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> rtl/core/crcf_checker.sv
// Port-level checks for the CRC-8 frame codec, bound to the top level.
`timescale 1ns / 1ps

module crcf_checker
  import crcf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // Hold a stalled result word.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // An encoded frame carries the start code and no decode fields.
  a_encode_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.frame_out != 64'd0 |->
      rsp.frame_out[START_BITS-1:0] == START_CODE && rsp.status == STATUS_OK &&
      rsp.src_out == 4'd0 && rsp.length_out == 16'd0 && rsp.payload_out == 32'd0)
    else $error("malformed encode result");

  // Drop all fields on a decode error.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STATUS_OK |->
      rsp.frame_out == 64'd0 && rsp.src_out == 4'd0 &&
      rsp.length_out == 16'd0 && rsp.payload_out == 32'd0)
    else $error("fields not cleared on error");

  // Take a request whenever the result side is free.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("request stalled with empty result stage");

endmodule

bind crc8_packet_framer_deframer crcf_checker u_crcf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
